@@ rtl/sensor_raw_compensation_macros.svh @@
// assertion macros used by the sensor compensation sequencer
`ifndef SENSOR_RAW_COMPENSATION_MACROS_SVH
`define SENSOR_RAW_COMPENSATION_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define SRC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define SRC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/src_pkg.sv @@
// shared types, step codes, constants and helpers of the sensor compensation block
package src_pkg;

   // channel codes
   localparam logic [1:0] OP_TEMP  = 2'd0;
   localparam logic [1:0] OP_PRESS = 2'd1;
   localparam logic [1:0] OP_HUM   = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // register indexes
   localparam logic [2:0] REG_TEMP    = 3'd0;
   localparam logic [2:0] REG_PRESS_A = 3'd1;
   localparam logic [2:0] REG_PRESS_B = 3'd2;
   localparam logic [2:0] REG_PRESS_9 = 3'd3;
   localparam logic [2:0] REG_HUM_A   = 3'd4;
   localparam logic [2:0] REG_HUM_B   = 3'd5;

   localparam int unsigned CSR_AW = 6;
   localparam int unsigned CSR_DW = 64;

   // formula constants
   localparam logic [63:0] C_FINE_OFF    = 64'd128000;
   localparam logic [11:0] C_PRESS_SCALE = 12'd3125;
   localparam logic [63:0] C_PRESS_BASE  = 64'd1048576;
   localparam logic [63:0] C_PRESS_ONE   = 64'h0000_8000_0000_0000;
   localparam logic [31:0] C_HUM_OFF     = 32'd76800;
   localparam logic [31:0] C_HUM_MAX     = 32'd419430400;
   localparam logic [31:0] C_HUM_S4      = 32'd2097152;
   localparam logic [31:0] C_HUM_RND     = 32'd16384;
   localparam logic [31:0] C_HUM_S5      = 32'd8192;
   localparam logic [31:0] C_HUM_S3      = 32'd32768;
   localparam logic [31:0] C_TEMP_RND    = 32'd128;

   // sequencer steps, one group per channel
   typedef enum logic [5:0] {
      S_T0 = 6'd0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6,
      S_P0 = 6'd8, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10,
      S_P11, S_P12, S_P13, S_P14, S_P15, S_P16, S_P17, S_P18, S_P19, S_P20,
      S_P21, S_P22,
      S_H0 = 6'd32, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8, S_H9,
      S_H10, S_H11, S_H12, S_H13, S_H14, S_H15, S_H16,
      S_NOP = 6'd56
   } step_type;

   typedef enum logic [1:0] {K_ALU, K_MUL, K_DIV, K_FIN} kind_type;

   typedef struct packed {
      logic     accept;
      step_type step;
      logic     exec;
      logic     mul_start;
      logic     div_start;
      logic     load_out;
   } cmd_type;

   typedef struct packed {
      logic abort;
      logic mul_done;
      logic div_done;
   } sts_type;

   typedef struct packed {
      logic [47:0] temp;
      logic [63:0] press_a;
      logic [63:0] press_b;
      logic [15:0] press_9;
      logic [31:0] hum_a;
      logic [39:0] hum_b;
   } coeff_type;

   function automatic kind_type step_kind(input step_type s);
      unique case (s) inside
         S_T1, S_T3, S_T5, S_P1, S_P3, S_P5, S_P7, S_P9, S_P11, S_P14, S_P17,
         S_P19, S_P21, S_H1, S_H3, S_H5, S_H7, S_H9, S_H11, S_H13, S_H15:
            return K_MUL;
         S_P15:
            return K_DIV;
         S_T6, S_P22, S_H16, S_NOP:
            return K_FIN;
         default:
            return K_ALU;
      endcase
   endfunction

   function automatic step_type start_step(input logic [1:0] op);
      unique case (op)
         OP_TEMP:  return S_T0;
         OP_PRESS: return S_P0;
         OP_HUM:   return S_H0;
         default:  return S_NOP;
      endcase
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
      return 32'($signed(v) >>> n);
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned n);
      return 64'($signed(v) >>> n);
   endfunction

   function automatic logic [63:0] sx16_64(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx16_32(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx8_32(input logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

   function automatic logic [63:0] sx32_64(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

endpackage

@@ rtl/src_csr.sv @@
// coefficient register file behind the configuration port
module src_csr import src_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output coeff_type         coeff
);

   coeff_type regs_ff;
   logic      wr;

   assign wr    = psel && penable && pwrite;
   assign coeff = regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else if (wr) begin
         unique case (paddr[5:3])
            REG_TEMP:    regs_ff.temp    <= pwdata[47:0];
            REG_PRESS_A: regs_ff.press_a <= pwdata;
            REG_PRESS_B: regs_ff.press_b <= pwdata;
            REG_PRESS_9: regs_ff.press_9 <= pwdata[15:0];
            REG_HUM_A:   regs_ff.hum_a   <= pwdata[31:0];
            REG_HUM_B:   regs_ff.hum_b   <= pwdata[39:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[5:3])
         REG_TEMP:    prdata = {16'b0, regs_ff.temp};
         REG_PRESS_A: prdata = regs_ff.press_a;
         REG_PRESS_B: prdata = regs_ff.press_b;
         REG_PRESS_9: prdata = {48'b0, regs_ff.press_9};
         REG_HUM_A:   prdata = {32'b0, regs_ff.hum_a};
         REG_HUM_B:   prdata = {24'b0, regs_ff.hum_b};
         default:     prdata = '0;
      endcase
   end

endmodule

@@ rtl/src_mul.sv @@
// shift-add multiplier, one multiplier bit per cycle, low 64 product bits
module src_mul import src_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   input  logic [6:0]  nbits,
   input  logic        sgn,
   output logic        done,
   output logic [63:0] result
);

   logic        busy_ff, busy_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [6:0]  n_ff;
   logic        sgn_ff;
   logic [63:0] acc_ff, ash_ff, bsh_ff;
   logic [63:0] term;
   logic        last;

   assign last   = (cnt_ff == n_ff - 7'd1);
   assign term   = bsh_ff[0] ? ash_ff : '0;
   // top bit of a signed multiplier weighs negative
   assign result = (last && sgn_ff) ? acc_ff - term : acc_ff + term;
   assign done   = busy_ff && last;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 7'd1;
         if (last) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         ash_ff <= a;
         bsh_ff <= b;
         n_ff   <= nbits;
         sgn_ff <= sgn;
      end else if (busy_ff) begin
         acc_ff <= result;
         ash_ff <= {ash_ff[62:0], 1'b0};
         bsh_ff <= {1'b0, bsh_ff[63:1]};
      end
   end

endmodule

@@ rtl/src_div.sv @@
// signed 64-bit restoring divider, one quotient bit per cycle
module src_div import src_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] quo
);

   logic        busy_ff;
   logic [5:0]  cnt_ff;
   logic        neg_ff;
   logic [63:0] rem_ff, q_ff, den_ff;
   logic [64:0] trial;
   logic [65:0] diff;
   logic        ge;
   logic [63:0] q_next;

   assign trial  = {rem_ff, q_ff[63]};
   assign diff   = {1'b0, trial} - {2'b0, den_ff};
   assign ge     = !diff[65];
   assign q_next = {q_ff[62:0], ge};
   assign done   = busy_ff && (cnt_ff == 6'd63);
   assign quo    = neg_ff ? (64'd0 - q_next) : q_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (done) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         q_ff   <= num[63] ? (64'd0 - num) : num;
         den_ff <= den[63] ? (64'd0 - den) : den;
         neg_ff <= num[63] ^ den[63];
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[63:0] : trial[63:0];
         q_ff   <= q_next;
      end
   end

endmodule

@@ rtl/src_ctrl.sv @@
// sequencer state machine of the compensation block
`include "sensor_raw_compensation_macros.svh"
module src_ctrl import src_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic [1:0] req_op,
   output logic       req_tready,
   input  logic       rsp_tready,
   output logic       rsp_tvalid,
   input  sts_type    sts,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RUN  = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;
   kind_type  kind;

   assign kind       = step_kind(step_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd           = '0;
      cmd.step      = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               step_in    = start_step(req_op);
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.exec = 1'b1;
            unique case (kind)
               K_MUL: begin
                  cmd.mul_start = 1'b1;
                  state_in      = ST_MUL;
               end
               K_DIV: begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end
               K_FIN: state_in = ST_OUT;
               default: begin
                  if (sts.abort) state_in = ST_OUT;
                  else step_in = step_type'(step_ff + 6'd1);
               end
            endcase
         end
         ST_MUL: begin
            if (sts.mul_done) begin
               step_in  = step_type'(step_ff + 6'd1);
               state_in = ST_RUN;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               step_in  = step_type'(step_ff + 6'd1);
               state_in = ST_RUN;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= S_NOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SRC_ASSERT_NXT(a_accept_runs, cmd.accept, state_ff == ST_RUN, "accepted transaction did not start")
   `SRC_ASSERT_IMP(a_mul_in_wait, sts.mul_done, state_ff == ST_MUL, "multiplier done outside wait")
   `SRC_ASSERT_IMP(a_div_in_wait, sts.div_done, state_ff == ST_DIV, "divider done outside wait")
   `SRC_ASSERT_IMP(a_slot_free, cmd.load_out, !rsp_valid_ff || rsp_tready, "result overwritten")

endmodule

@@ rtl/src_dp.sv @@
// datapath: working registers, step arithmetic, multiplier and divider
module src_dp import src_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [1:0]  req_op,
   input  logic [19:0] req_raw,
   input  coeff_type   coeff,
   output sts_type     sts,
   output logic [1:0]  rsp_channel,
   output logic [32:0] rsp_value,
   output logic        rsp_invalid
);

   logic [1:0]  op_ff;
   logic [19:0] raw_ff;
   logic [63:0] a_ff, b_ff, c_ff, d_ff, e_ff, p_ff;
   logic [31:0] fine_ff;
   logic [32:0] res_ff;
   logic        bad_ff;
   logic [1:0]  chan_out_ff;
   logic [32:0] value_out_ff;
   logic        bad_out_ff;

   logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2, h4, h5;
   logic [7:0]  h1, h3, h6;

   logic [63:0] mul_a, mul_b, mul_res, div_res;
   logic [6:0]  mul_n;
   logic        mul_sgn, mul_done, div_done;

   logic [31:0] p32;
   logic [31:0] t_a0, t_a2, fine_next, t_five, t_res;
   logic [63:0] p_check, p_e, p_sum, p_res;
   logic [31:0] h_s1, h_x, h_clamp;

   assign t1 = coeff.temp[15:0];
   assign t2 = coeff.temp[31:16];
   assign t3 = coeff.temp[47:32];
   assign p1 = coeff.press_a[15:0];
   assign p2 = coeff.press_a[31:16];
   assign p3 = coeff.press_a[47:32];
   assign p4 = coeff.press_a[63:48];
   assign p5 = coeff.press_b[15:0];
   assign p6 = coeff.press_b[31:16];
   assign p7 = coeff.press_b[47:32];
   assign p8 = coeff.press_b[63:48];
   assign p9 = coeff.press_9;
   assign h1 = coeff.hum_a[7:0];
   assign h2 = coeff.hum_a[23:8];
   assign h3 = coeff.hum_a[31:24];
   assign h4 = coeff.hum_b[15:0];
   assign h5 = coeff.hum_b[31:16];
   assign h6 = coeff.hum_b[39:32];

   assign p32 = p_ff[31:0];

   // temperature
   assign t_a0      = {15'b0, raw_ff[19:3]} - {15'b0, t1, 1'b0};
   assign t_a2      = {16'b0, raw_ff[19:4]} - {16'b0, t1};
   assign fine_next = b_ff[31:0] + asr32(p32, 14);
   assign t_five    = {fine_next[29:0], 2'b0} + fine_next + C_TEMP_RND;
   assign t_res     = asr32(t_five, 8);

   // pressure
   assign p_check = asr64(p_ff, 33);
   assign p_e     = ((C_PRESS_BASE - {44'b0, raw_ff}) << 31) - c_ff;
   assign p_sum   = a_ff + c_ff + asr64(p_ff, 19);
   assign p_res   = asr64(p_sum, 8) + (sx16_64(p7) << 4);

   // humidity
   assign h_s1 = asr32({2'b0, raw_ff[15:0], 14'b0} - (sx16_32(h4) << 20) - p32 + C_HUM_RND, 15);
   assign h_x  = a_ff[31:0] - asr32(p32, 4);
   always_comb begin
      if (h_x[31])             h_clamp = '0;
      else if (h_x > C_HUM_MAX) h_clamp = C_HUM_MAX;
      else                     h_clamp = h_x;
   end

   // multiplier operands per step
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_n   = 7'd64;
      mul_sgn = 1'b0;
      case (cmd.step)
         S_T1:  begin mul_a = a_ff; mul_b = {48'b0, t2}; mul_n = 7'd16; mul_sgn = 1'b1; end
         S_T3:  begin mul_a = a_ff; mul_b = a_ff; mul_n = 7'd32; end
         S_T5:  begin mul_a = a_ff; mul_b = {48'b0, t3}; mul_n = 7'd16; mul_sgn = 1'b1; end
         S_P1:  begin mul_a = a_ff; mul_b = a_ff; end
         S_P3:  begin mul_a = b_ff; mul_b = {48'b0, p6}; mul_n = 7'd16; mul_sgn = 1'b1; end
         S_P5:  begin mul_a = a_ff; mul_b = {48'b0, p5}; mul_n = 7'd16; mul_sgn = 1'b1; end
         S_P7:  begin mul_a = b_ff; mul_b = {48'b0, p3}; mul_n = 7'd16; mul_sgn = 1'b1; end
         S_P9:  begin mul_a = a_ff; mul_b = {48'b0, p2}; mul_n = 7'd16; mul_sgn = 1'b1; end
         S_P11: begin mul_a = d_ff; mul_b = {48'b0, p1}; mul_n = 7'd16; end
         S_P14: begin mul_a = e_ff; mul_b = {52'b0, C_PRESS_SCALE}; mul_n = 7'd12; end
         S_P17: begin mul_a = b_ff; mul_b = {48'b0, p9}; mul_n = 7'd16; mul_sgn = 1'b1; end
         S_P19: begin mul_a = c_ff; mul_b = b_ff; end
         S_P21: begin mul_a = a_ff; mul_b = {48'b0, p8}; mul_n = 7'd16; mul_sgn = 1'b1; end
         S_H1:  begin mul_a = a_ff; mul_b = {48'b0, h5}; mul_n = 7'd16; mul_sgn = 1'b1; end
         S_H3:  begin mul_a = a_ff; mul_b = {56'b0, h6}; mul_n = 7'd8; mul_sgn = 1'b1; end
         S_H5:  begin mul_a = a_ff; mul_b = {56'b0, h3}; mul_n = 7'd8; end
         S_H7:  begin mul_a = c_ff; mul_b = d_ff; mul_n = 7'd32; end
         S_H9:  begin mul_a = c_ff; mul_b = {48'b0, h2}; mul_n = 7'd16; mul_sgn = 1'b1; end
         S_H11: begin mul_a = b_ff; mul_b = c_ff; mul_n = 7'd32; end
         S_H13: begin mul_a = d_ff; mul_b = d_ff; mul_n = 7'd32; end
         S_H15: begin mul_a = d_ff; mul_b = {56'b0, h1}; mul_n = 7'd8; end
         default: ;
      endcase
   end

   src_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .nbits  (mul_n),
      .sgn    (mul_sgn),
      .done   (mul_done),
      .result (mul_res)
   );

   src_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (p_ff),
      .den   (d_ff),
      .done  (div_done),
      .quo   (div_res)
   );

   assign sts.mul_done = mul_done;
   assign sts.div_done = div_done;
   assign sts.abort    = cmd.exec && (cmd.step == S_P12) && (p_check == '0);

   // kept fine temperature
   always_ff @(posedge clock) begin
      if (reset) fine_ff <= '0;
      else if (cmd.exec && cmd.step == S_T6) fine_ff <= fine_next;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_op;
         raw_ff <= req_raw;
      end
      if (mul_done) p_ff <= mul_res;
      else if (div_done) p_ff <= div_res;
      if (cmd.exec) begin
         case (cmd.step)
            S_T0:  a_ff <= {32'b0, t_a0};
            S_T2:  begin b_ff <= {32'b0, asr32(p32, 11)}; a_ff <= {32'b0, t_a2}; end
            S_T4:  a_ff <= {32'b0, asr32(p32, 12)};
            S_T6:  begin res_ff <= {t_res[31], t_res}; bad_ff <= 1'b0; end
            S_P0:  a_ff <= sx32_64(fine_ff) - C_FINE_OFF;
            S_P2:  b_ff <= p_ff;
            S_P4:  c_ff <= p_ff;
            S_P6:  c_ff <= c_ff + (p_ff << 17) + (sx16_64(p4) << 35);
            S_P8:  d_ff <= asr64(p_ff, 8);
            S_P10: d_ff <= d_ff + (p_ff << 12) + C_PRESS_ONE;
            // zero divisor: result 0 flagged, sequence stops here
            S_P12: begin d_ff <= p_check; res_ff <= '0; bad_ff <= 1'b1; end
            S_P13: e_ff <= p_e;
            S_P16: begin a_ff <= p_ff; b_ff <= asr64(p_ff, 13); end
            S_P18: c_ff <= p_ff;
            S_P20: c_ff <= asr64(p_ff, 25);
            S_P22: begin res_ff <= {1'b0, p_res[31:0]}; bad_ff <= 1'b0; end
            S_H0:  a_ff <= {32'b0, fine_ff - C_HUM_OFF};
            S_H2:  b_ff <= {32'b0, h_s1};
            S_H4:  c_ff <= {32'b0, asr32(p32, 10)};
            S_H6:  d_ff <= {32'b0, asr32(p32, 11) + C_HUM_S3};
            S_H8:  c_ff <= {32'b0, asr32(p32, 10) + C_HUM_S4};
            S_H10: c_ff <= {32'b0, asr32(p32 + C_HUM_S5, 14)};
            S_H12: begin a_ff <= {32'b0, p32}; d_ff <= {32'b0, asr32(p32, 15)}; end
            S_H14: d_ff <= {32'b0, asr32(p32, 7)};
            S_H16: begin res_ff <= {13'b0, h_clamp[31:12]}; bad_ff <= 1'b0; end
            S_NOP: begin res_ff <= '0; bad_ff <= 1'b0; end
            default: ;
         endcase
      end
      if (cmd.load_out) begin
         chan_out_ff  <= op_ff;
         value_out_ff <= res_ff;
         bad_out_ff   <= bad_ff;
      end
   end

   assign rsp_channel = chan_out_ff;
   assign rsp_value   = value_out_ff;
   assign rsp_invalid = bad_out_ff;

endmodule

@@ rtl/sensor_raw_compensation.sv @@
// top level of the raw sensor reading compensation block
//
//  channel   group  payload
//  -------   -----  -----------------------------------------------
//  input     req_   tuser: op[1:0]; tdata: raw_sample[19:0]
//  result    rsp_   tuser: channel[1:0], pressure_invalid[2];
//                   tdata: value[32:0] (signed)
//  config    csr_   64-bit registers at byte address 8*index
//
//  one transaction at a time; the run time is set by the shift-add multiplier
//  (one multiplier bit per cycle) and the restoring divider; a pressure reading
//  whose divisor is zero stops early and channel code 3 goes straight to the
//  result; input is ready again in the cycle after the result is loaded
//  reset is synchronous and active high: the coefficient registers and the
//  kept fine temperature go to zero
//  a finished result waits in the output register while the next input
//  transaction is taken; it is only held back again when that one finishes
module sensor_raw_compensation import src_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // input transaction
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // [19:0] raw_sample
   input  logic [1:0]        req_tuser,   // [1:0] op
   // result transaction
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // [32:0] value
   output logic [2:0]        rsp_tuser,   // [1:0] channel, [2] pressure_invalid
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   coeff_type   coeff;
   cmd_type     cmd;
   sts_type     sts;
   logic [1:0]  out_channel;
   logic [32:0] out_value;
   logic        out_invalid;

   // no wait states on the register port
   assign csr_pready = 1'b1;

   src_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .coeff   (coeff)
   );

   // sequencer: walks the step list of the channel
   src_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .sts        (sts),
      .cmd        (cmd)
   );

   // arithmetic and the output register
   src_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_op      (req_tuser),
      .req_raw     (req_tdata[19:0]),
      .coeff       (coeff),
      .sts         (sts),
      .rsp_channel (out_channel),
      .rsp_value   (out_value),
      .rsp_invalid (out_invalid)
   );

   assign rsp_tdata = {7'b0, out_value};
   assign rsp_tuser = {out_invalid, out_channel};

endmodule

@@ bench/sensor_raw_compensation_tb.sv @@
// testbench of the sensor raw compensation block: directed and random readings per channel
`timescale 1ns / 100ps

module sensor_raw_compensation_tb import src_pkg::*; ;

   typedef struct packed {
      logic [1:0]  channel;
      logic [32:0] value;
      logic        press_bad;
   } reading_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [23:0]       req_tdata;   // [19:0] raw_sample
   logic [1:0]        req_tuser;   // [1:0] op
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [39:0]       rsp_tdata;   // [32:0] value
   logic [2:0]        rsp_tuser;   // [1:0] channel, [2] pressure_invalid
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // model copy of the coefficient registers and kept fine temperature
   coeff_type   coef;
   logic [31:0] fine_t;

   reading_type expected_readings[$];
   int          mismatch_count;
   int          idle_cycles;
   int          rsp_wait;

   sensor_raw_compensation i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // predictor: integer compensation formulas on the model copy of the coefficients
   // ---------------------------------------------------------------------------------
   function automatic logic [31:0] sra32(input logic [31:0] v, input int n);
      return $signed(v) >>> n;
   endfunction

   function automatic logic [63:0] sra64(input logic [63:0] v, input int n);
      return $signed(v) >>> n;
   endfunction

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [63:0] sext32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic [31:0] temperature_x100(input logic [19:0] adc);
      logic [31:0] t1, t2, t3, a, v1, d, v2;
      t1 = {16'd0, coef.temp[15:0]};
      t2 = sext16(coef.temp[31:16]);
      t3 = sext16(coef.temp[47:32]);
      a  = {12'd0, adc} >> 3;
      a  = a - (t1 << 1);
      v1 = sra32(a * t2, 11);
      d  = ({12'd0, adc} >> 4) - t1;
      v2 = sra32(sra32(d * d, 12) * t3, 14);
      fine_t = v1 + v2;
      return sra32(fine_t * 32'd5 + 32'd128, 8);
   endfunction

   // returns 0 in ok when the divisor works out to zero
   function automatic logic [31:0] pressure_q24_8(input logic [19:0] adc, output bit ok);
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, n, q, mn, md;
      p1 = {48'd0, coef.press_a[15:0]};
      p2 = sext32(sext16(coef.press_a[31:16]));
      p3 = sext32(sext16(coef.press_a[47:32]));
      p4 = sext32(sext16(coef.press_a[63:48]));
      p5 = sext32(sext16(coef.press_b[15:0]));
      p6 = sext32(sext16(coef.press_b[31:16]));
      p7 = sext32(sext16(coef.press_b[47:32]));
      p8 = sext32(sext16(coef.press_b[63:48]));
      p9 = sext32(sext16(coef.press_9));
      v1 = sext32(fine_t) - 64'd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
      v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
      ok = (v1 != 64'd0);
      if (!ok) return 32'd0;
      p  = 64'd1048576 - {44'd0, adc};
      n  = ((p << 31) - v2) * 64'd3125;
      // signed division truncating toward zero, most negative over -1 wraps
      mn = n[63] ? -n : n;
      md = v1[63] ? -v1 : v1;
      q  = mn / md;
      p  = (n[63] != v1[63]) ? -q : q;
      v1 = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
      v2 = sra64(p8 * p, 19);
      p  = sra64(p + v1 + v2, 8) + (p7 << 4);
      return p[31:0];
   endfunction

   function automatic logic [31:0] humidity_q22_10(input logic [19:0] adc);
      logic [31:0] h1, h2, h3, h4, h5, h6, h, x, s1, s2, s3, s4, s5;
      h1 = {24'd0, coef.hum_a[7:0]};
      h2 = sext16(coef.hum_a[23:8]);
      h3 = {24'd0, coef.hum_a[31:24]};
      h4 = sext16(coef.hum_b[15:0]);
      h5 = sext16(coef.hum_b[31:16]);
      h6 = {{24{coef.hum_b[39]}}, coef.hum_b[39:32]};
      h  = {16'd0, adc[15:0]};
      x  = fine_t - 32'd76800;
      s1 = sra32(((h << 14) - (h4 << 20) - (h5 * x)) + 32'd16384, 15);
      s2 = sra32(x * h6, 10);
      s3 = sra32(x * h3, 11) + 32'd32768;
      s4 = sra32(s2 * s3, 10) + 32'd2097152;
      s5 = sra32(s4 * h2 + 32'd8192, 14);
      x  = s1 * s5;
      x  = x - sra32(sra32(sra32(x, 15) * sra32(x, 15), 7) * h1, 4);
      if (x[31]) x = 32'd0;
      else if (x > 32'd419430400) x = 32'd419430400;
      return x >> 12;
   endfunction

   function automatic reading_type compensate(input logic [1:0] op, input logic [19:0] raw);
      reading_type r;
      bit          ok;
      logic [31:0] v;
      r = '0;
      r.channel = op;
      case (op)
         OP_TEMP: begin
            v = temperature_x100(raw);
            r.value = {v[31], v};
         end
         OP_PRESS: begin
            v = pressure_q24_8(raw, ok);
            r.value = {1'b0, v};
            r.press_bad = !ok;
         end
         OP_HUM: begin
            v = humidity_q22_10(raw);
            r.value = {1'b0, v};
         end
         default: r.value = '0;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // register write in setup and access cycles, only while the block is idle
   task automatic write_coeff(input logic [2:0] idx, input logic [63:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(idx) << 3;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_TEMP:    coef.temp    = data[47:0];
         REG_PRESS_A: coef.press_a = data;
         REG_PRESS_B: coef.press_b = data;
         REG_PRESS_9: coef.press_9 = data[15:0];
         REG_HUM_A:   coef.hum_a   = data[31:0];
         REG_HUM_B:   coef.hum_b   = data[39:0];
         default: ;
      endcase
   endtask

   // sends one reading; the prediction is queued at the accepting edge
   // valid stays high after acceptance so a zero gap gives back-to-back offers
   task automatic send_reading(input logic [1:0] op, input logic [19:0] raw);
      int gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, raw};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_readings.push_back(compensate(op, raw));
   endtask

   // lets every queued reading come back, then idles a while
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   function automatic logic [1:0] random_op();
      int k;
      k = $urandom_range(0, 19);
      if (k < 7) return OP_TEMP;
      if (k < 13) return OP_PRESS;
      if (k < 19) return OP_HUM;
      return OP_NONE;
   endfunction

   // plausible calibration sets: coefficients near the sensor's usual ranges
   task automatic load_typical_coeffs();
      logic [15:0] t1, p1;
      t1 = 16'(27000 + $urandom_range(0, 2000));
      write_coeff(REG_TEMP, {16'd0, 16'($signed(-1000 + $urandom_range(0, 2000))),
                             16'(26000 + $urandom_range(0, 1000)), t1});
      p1 = 16'(35000 + $urandom_range(0, 3000));
      write_coeff(REG_PRESS_A, {16'(7000 + $urandom_range(0, 2000)),
                                16'($signed(3000 + $urandom_range(0, 2000))),
                                16'($signed(-11000 + $urandom_range(0, 1000))), p1});
      write_coeff(REG_PRESS_B, {16'($signed(-12000 + $urandom_range(0, 2000))),
                                16'($signed(9000 + $urandom_range(0, 2000))),
                                16'($signed(-7 + $urandom_range(0, 14))),
                                16'($signed(-100 + $urandom_range(0, 200)))});
      write_coeff(REG_PRESS_9, 64'(16'(4000 + $urandom_range(0, 1000))));
      write_coeff(REG_HUM_A, {32'd0, 8'd0, 16'(300 + $urandom_range(0, 200)),
                              8'(50 + $urandom_range(0, 50))});
      write_coeff(REG_HUM_B, {24'd0, 8'(30), 16'(50), 16'(250 + $urandom_range(0, 200))});
   endtask

   task automatic load_random_coeffs();
      write_coeff(REG_TEMP,    {$urandom, $urandom});
      write_coeff(REG_PRESS_A, {$urandom, $urandom});
      write_coeff(REG_PRESS_B, {$urandom, $urandom});
      write_coeff(REG_PRESS_9, {$urandom, $urandom});
      write_coeff(REG_HUM_A,   {$urandom, $urandom});
      write_coeff(REG_HUM_B,   {$urandom, $urandom});
   endtask

   // ---------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------
   // all coefficients zero after reset: the pressure divisor is zero
   task automatic test_reset_coeffs();
      send_reading(OP_PRESS, 20'd0);
      send_reading(OP_TEMP, 20'hFFFFF);
      send_reading(OP_HUM, 20'd0);
      send_reading(OP_NONE, 20'hFFFFF);
      drain_results();
   endtask

   // field extremes, every channel, humidity high bits, channel code 3
   task automatic test_directed_extremes();
      write_coeff(REG_TEMP,    64'h0000_8000_7FFF_FFFF);
      write_coeff(REG_PRESS_A, 64'h7FFF_8000_7FFF_FFFF);
      write_coeff(REG_PRESS_B, 64'h8000_7FFF_8000_7FFF);
      write_coeff(REG_PRESS_9, 64'h0000_0000_0000_8000);
      write_coeff(REG_HUM_A,   64'h0000_0000_FF80_00FF);
      write_coeff(REG_HUM_B,   64'h0000_0080_8000_7FFF);
      send_reading(OP_TEMP, 20'd0);
      send_reading(OP_PRESS, 20'hFFFFF);
      send_reading(OP_HUM, 20'hFFFFF);
      send_reading(OP_TEMP, 20'hFFFFF);
      send_reading(OP_PRESS, 20'd0);
      send_reading(OP_HUM, 20'h0FFFF);
      send_reading(OP_HUM, 20'hF0000);
      send_reading(OP_NONE, 20'h55555);
      send_reading(OP_PRESS, 20'hAAAAA);
      drain_results();
      write_coeff(REG_TEMP,    64'hFFFF_FFFF_FFFF_FFFF);
      write_coeff(REG_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
      write_coeff(REG_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF);
      write_coeff(REG_PRESS_9, 64'hFFFF_FFFF_FFFF_FFFF);
      write_coeff(REG_HUM_A,   64'hFFFF_FFFF_FFFF_FFFF);
      write_coeff(REG_HUM_B,   64'hFFFF_FFFF_FFFF_FFFF);
      send_reading(OP_TEMP, 20'h80000);
      send_reading(OP_PRESS, 20'h7FFFF);
      send_reading(OP_HUM, 20'h08000);
      send_reading(OP_NONE, 20'd0);
      drain_results();
   endtask

   // realistic calibrations, the humidity clamp and divide paths get real data
   task automatic test_typical_random(input int count);
      load_typical_coeffs();
      for (int i = 0; i < count; i++) begin
         if (i % 10 == 0) send_reading(OP_TEMP, 20'(400000 + $urandom_range(0, 300000)));
         else send_reading(random_op(), 20'($urandom));
      end
      drain_results();
   endtask

   task automatic test_wild_random(input int count);
      load_random_coeffs();
      for (int i = 0; i < count; i++)
         send_reading(random_op(), 20'($urandom));
      drain_results();
   endtask

   // ---------------------------------------------------------------------------------
   // result checking and receiver stalls
   // ---------------------------------------------------------------------------------
   // a fresh random wait is drawn after every result
   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         w = $urandom_range(0, 6);
         rsp_wait   <= w;
         rsp_tready <= (w == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait   <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            report_mismatch("unexpected transaction", 64'({rsp_tuser, rsp_tdata}), '0);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_tuser[1:0] !== want.channel)
               report_mismatch("channel", 64'(rsp_tuser[1:0]), 64'(want.channel));
            if (rsp_tdata[32:0] !== want.value)
               report_mismatch("value", 64'(rsp_tdata[32:0]), 64'(want.value));
            if (rsp_tuser[2] !== want.press_bad)
               report_mismatch("pressure_invalid", 64'(rsp_tuser[2]), 64'(want.press_bad));
         end
      end
   end

   // watchdog on cycles with no accepted transaction anywhere
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      coef        = '0;
      fine_t      = '0;
      mismatch_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_coeffs();
      test_directed_extremes();
      test_typical_random(300);
      test_wild_random(120);
      test_typical_random(200);
      test_wild_random(80);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/src_pkg.sv
rtl/src_csr.sv
rtl/src_mul.sv
rtl/src_div.sv
rtl/src_ctrl.sv
rtl/src_dp.sv
rtl/sensor_raw_compensation.sv
bench/sensor_raw_compensation_tb.sv
